[hdl/rpi_pkg.sv]
// ----------------------------------------------------------------------------
// rpi_pkg: shared constants and types for the ray/plane intersection core
// Widths of the coordinate fields, register reset value and the bundle of
// ray data that travels down the pipeline next to the arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

package rpi_pkg;

   // Width of every coordinate field and of the epsilon register.
   localparam int COORD_W = 32;
   localparam int EPS_W   = 16;

   // Magnitude bits of the ray parameter t.
   localparam int T_W = 31;

   // Default number of fraction bits.
   localparam int FRAC_BITS_DEFAULT = 16;

   // Register reset value.
   localparam logic [EPS_W-1:0] EPS_RESET = 16'd7;

   // Ray origin and direction carried alongside the arithmetic.
   typedef struct packed {
      logic [2:0][COORD_W-1:0] org;
      logic [2:0][COORD_W-1:0] dir;
   } ray_carry_type;

endpackage

`default_nettype wire

[hdl/ray_plane_intersect_core.sv]
// ----------------------------------------------------------------------------
// ray_plane_intersect_core: pipelined ray/plane intersection
// Dot products, a one-bit-per-stage restoring divider for t and the hit point
// multiply, all in signed fixed point.
// ----------------------------------------------------------------------------
// A request is taken in every cycle in which start is high; busy is always low.
// Each request yields one result, shown on the rsp_ ports for one cycle with
// rsp_valid high. A request passes 38 register stages at any FRAC_BITS (five
// setup stages, 31 divider stages, one multiply stage and one add/saturate
// stage), the last of which are the rsp_ result registers. The 31-stage
// divider sets the latency; throughput is one request per cycle. Results
// cannot be held off, so the receiver must take them when they appear. Change
// csr_wr_data only while no request is in flight.
`default_nettype none

module ray_plane_intersect_core #(
   parameter int FRAC_BITS = rpi_pkg::FRAC_BITS_DEFAULT
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               start,
   output logic                              busy,
   input  wire signed [rpi_pkg::COORD_W-1:0] req_origin_x,
   input  wire signed [rpi_pkg::COORD_W-1:0] req_origin_y,
   input  wire signed [rpi_pkg::COORD_W-1:0] req_origin_z,
   input  wire signed [rpi_pkg::COORD_W-1:0] req_dir_x,
   input  wire signed [rpi_pkg::COORD_W-1:0] req_dir_y,
   input  wire signed [rpi_pkg::COORD_W-1:0] req_dir_z,
   input  wire signed [rpi_pkg::COORD_W-1:0] req_normal_x,
   input  wire signed [rpi_pkg::COORD_W-1:0] req_normal_y,
   input  wire signed [rpi_pkg::COORD_W-1:0] req_normal_z,
   input  wire signed [rpi_pkg::COORD_W-1:0] req_plane_pt_x,
   input  wire signed [rpi_pkg::COORD_W-1:0] req_plane_pt_y,
   input  wire signed [rpi_pkg::COORD_W-1:0] req_plane_pt_z,
   input  wire                               csr_wr_en,
   input  wire        [rpi_pkg::EPS_W-1:0]   csr_wr_data,
   output logic                              rsp_valid,
   output logic                              rsp_hit_found,
   output logic signed [rpi_pkg::COORD_W-1:0] rsp_hit_x,
   output logic signed [rpi_pkg::COORD_W-1:0] rsp_hit_y,
   output logic signed [rpi_pkg::COORD_W-1:0] rsp_hit_z
);

   localparam int CW    = rpi_pkg::COORD_W;
   localparam int TW    = rpi_pkg::T_W;
   localparam int PN_W  = 2 * CW;            // normal * direction
   localparam int PM_W  = 2 * CW + 1;        // (point - origin) * normal
   localparam int DEN_W = PN_W - FRAC_BITS + 2;
   localparam int NUM_W = PM_W - FRAC_BITS + 2;
   localparam int CMP_W = DEN_W + TW;        // remainder and shifted divisor
   localparam int HS_W  = CW + TW + 2;       // direction * t and hit sum

   // The pipeline never stalls.
   assign busy = 1'b0;

   // Epsilon register.
   logic [rpi_pkg::EPS_W-1:0] eps_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= rpi_pkg::EPS_RESET;
      end else if (csr_wr_en) begin
         eps_ff <= csr_wr_data;
      end
   end

   // Stage 1: register inputs and form plane point minus origin.
   logic                             s1_vld_ff;
   rpi_pkg::ray_carry_type           s1_ray_ff;
   logic [2:0][CW-1:0]               s1_nrm_ff;
   logic [2:0][CW:0]                 s1_diff_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= start;
      end
      s1_ray_ff.org <= {req_origin_z, req_origin_y, req_origin_x};
      s1_ray_ff.dir <= {req_dir_z, req_dir_y, req_dir_x};
      s1_nrm_ff     <= {req_normal_z, req_normal_y, req_normal_x};
      s1_diff_ff[0] <= (CW+1)'(req_plane_pt_x) - (CW+1)'(req_origin_x);
      s1_diff_ff[1] <= (CW+1)'(req_plane_pt_y) - (CW+1)'(req_origin_y);
      s1_diff_ff[2] <= (CW+1)'(req_plane_pt_z) - (CW+1)'(req_origin_z);
   end

   // Stage 2: the six products.
   logic                   s2_vld_ff;
   rpi_pkg::ray_carry_type s2_ray_ff;
   logic [2:0][PN_W-1:0]   s2_pn_ff;
   logic [2:0][PM_W-1:0]   s2_pm_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
      s2_ray_ff <= s1_ray_ff;
      for (int k = 0; k < 3; k++) begin
         s2_pn_ff[k] <= PN_W'($signed(s1_nrm_ff[k]) * $signed(s1_ray_ff.dir[k]));
         s2_pm_ff[k] <= PM_W'($signed(s1_diff_ff[k]) * $signed(s1_nrm_ff[k]));
      end
   end

   // Stage 3: floor shift of each product and the two dot-product sums.
   logic signed [DEN_W-1:0] den_in;
   logic signed [NUM_W-1:0] num_in;
   always_comb begin
      logic signed [PN_W-1:0] sn;
      logic signed [PM_W-1:0] sm;
      den_in = '0;
      num_in = '0;
      for (int k = 0; k < 3; k++) begin
         sn = $signed(s2_pn_ff[k]) >>> FRAC_BITS;
         sm = $signed(s2_pm_ff[k]) >>> FRAC_BITS;
         den_in = den_in + $signed(DEN_W'(sn));
         num_in = num_in + $signed(NUM_W'(sm));
      end
   end

   logic                    s3_vld_ff;
   rpi_pkg::ray_carry_type  s3_ray_ff;
   logic signed [DEN_W-1:0] s3_den_ff;
   logic signed [NUM_W-1:0] s3_num_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s2_vld_ff;
      end
      s3_ray_ff <= s2_ray_ff;
      s3_den_ff <= den_in;
      s3_num_ff <= num_in;
   end

   // Stage 4: magnitudes and the sign tests.
   logic                   s4_vld_ff;
   rpi_pkg::ray_carry_type s4_ray_ff;
   logic [DEN_W-1:0]       s4_ud_ff;
   logic [NUM_W-1:0]       s4_un_ff;
   logic                   s4_behind_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else begin
         s4_vld_ff <= s3_vld_ff;
      end
      s4_ray_ff    <= s3_ray_ff;
      s4_ud_ff     <= s3_den_ff[DEN_W-1] ? DEN_W'(-s3_den_ff) : DEN_W'(s3_den_ff);
      s4_un_ff     <= s3_num_ff[NUM_W-1] ? NUM_W'(-s3_num_ff) : NUM_W'(s3_num_ff);
      s4_behind_ff <= (s3_num_ff == '0) || (s3_num_ff[NUM_W-1] != s3_den_ff[DEN_W-1]);
   end

   // Stage 5: parallel test, overflow test and divider setup.
   logic [CMP_W-1:0] ovf_lim;
   logic [CMP_W-1:0] dividend;
   assign ovf_lim  = CMP_W'(s4_ud_ff) << (TW - FRAC_BITS);
   assign dividend = CMP_W'(s4_un_ff) << FRAC_BITS;

   logic                   dv_vld_ff [0:TW];
   rpi_pkg::ray_carry_type dv_ray_ff [0:TW];
   logic [DEN_W-1:0]       dv_ud_ff  [0:TW-1];
   logic [CMP_W-1:0]       dv_rem_ff [0:TW-1];
   logic [TW-1:0]          dv_quo_ff [0:TW];
   logic                   dv_ok_ff  [0:TW];
   logic                   dv_ovf_ff [0:TW];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff[0] <= 1'b0;
      end else begin
         dv_vld_ff[0] <= s4_vld_ff;
      end
      dv_ray_ff[0] <= s4_ray_ff;
      dv_ud_ff[0]  <= s4_ud_ff;
      dv_rem_ff[0] <= dividend;
      dv_quo_ff[0] <= '0;
      dv_ok_ff[0]  <= (s4_ud_ff > DEN_W'(eps_ff)) && !s4_behind_ff;
      dv_ovf_ff[0] <= CMP_W'(s4_un_ff) >= ovf_lim;
   end

   // Divider: one quotient bit per stage, most significant first.
   for (genvar g = 0; g < TW; g++) begin : g_div
      localparam int BIT = TW - 1 - g;
      logic [CMP_W-1:0] sub;
      logic             take;
      assign sub  = CMP_W'(dv_ud_ff[g]) << BIT;
      assign take = dv_rem_ff[g] >= sub;
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[g+1] <= 1'b0;
         end else begin
            dv_vld_ff[g+1] <= dv_vld_ff[g];
         end
         dv_ray_ff[g+1] <= dv_ray_ff[g];
         dv_quo_ff[g+1] <= dv_quo_ff[g] | (take ? (TW'(1) << BIT) : '0);
         dv_ok_ff[g+1]  <= dv_ok_ff[g];
         dv_ovf_ff[g+1] <= dv_ovf_ff[g];
      end

      // Divisor and remainder are needed only up to the last quotient bit.
      if (g < TW - 1) begin : g_carry
         always_ff @(posedge clock) begin
            dv_ud_ff[g+1]  <= dv_ud_ff[g];
            dv_rem_ff[g+1] <= take ? dv_rem_ff[g] - sub : dv_rem_ff[g];
         end
      end
   end

   // Multiply stage: saturate t and scale the direction by it.
   logic [TW-1:0] tabs;
   assign tabs = dv_ovf_ff[TW] ? {TW{1'b1}} : dv_quo_ff[TW];

   logic                   m_vld_ff;
   logic                   m_hit_ff;
   logic [2:0][CW-1:0]     m_org_ff;
   logic [2:0][HS_W-1:0]   m_prod_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
      end else begin
         m_vld_ff <= dv_vld_ff[TW];
      end
      m_hit_ff <= dv_ok_ff[TW] && (tabs != '0);
      m_org_ff <= dv_ray_ff[TW].org;
      for (int k = 0; k < 3; k++) begin
         m_prod_ff[k] <= HS_W'($signed(dv_ray_ff[TW].dir[k]) * $signed({1'b0, tabs}));
      end
   end

   // Add and saturate stage, straight into the result registers.
   logic [2:0][CW-1:0] hit_in;
   always_comb begin
      logic signed [HS_W-1:0] s;
      for (int k = 0; k < 3; k++) begin
         s = ($signed(m_prod_ff[k]) >>> FRAC_BITS) + $signed(HS_W'($signed(m_org_ff[k])));
         if (!m_hit_ff) begin
            hit_in[k] = '0;
         end else if (s > $signed(HS_W'({1'b0, {(CW-1){1'b1}}}))) begin
            hit_in[k] = {1'b0, {(CW-1){1'b1}}};
         end else if (s < -$signed(HS_W'({1'b1, {(CW-1){1'b0}}}))) begin
            hit_in[k] = {1'b1, {(CW-1){1'b0}}};
         end else begin
            hit_in[k] = CW'(s);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= m_vld_ff;
      end
      rsp_hit_found <= m_hit_ff;
      rsp_hit_x     <= hit_in[0];
      rsp_hit_y     <= hit_in[1];
      rsp_hit_z     <= hit_in[2];
   end

endmodule

`default_nettype wire
